// ===== sv/assert_macros.svh =====
// assertion macros for the rtl files
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== sv/mkse_pkg.sv =====
// shared types, constants and helpers for the keypad scanner
// no dependencies
package mkse_pkg;

    localparam int NUM_COLUMNS_DEF = 4;
    localparam int NUM_ROWS_DEF    = 4;
    localparam int COL_W           = 2;
    localparam int KEY_W           = 4;
    localparam int KEYS            = 16;
    localparam int PORT_W          = 8;

    localparam logic [PORT_W-1:0] IDLE_DRIVE = 8'hF0;
    localparam logic [PORT_W-1:0] ALL_HIGH   = 8'hFF;

    // input operation codes
    typedef enum logic {
        OP_START  = 1'b0,
        OP_SAMPLE = 1'b1
    } t_op;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic step;
        logic load_event;
        logic load_last;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic go_walk;
        logic bit_changed;
        logic bit_end;
        logic out_free;
    } t_stat;

    // drive pattern with one column pulled low
    function automatic logic [PORT_W-1:0] col_drive(input logic [COL_W-1:0] col);
        logic [PORT_W-1:0] onehot;
        onehot = PORT_W'(1) << col;
        return ALL_HIGH & ~onehot;
    endfunction

endpackage

// ===== sv/mkse_channels.sv =====
// valid/ready channel interfaces for sample input and event output
// depends on mkse_pkg
interface mkse_in_if;
    logic                        valid;
    logic                        ready;
    logic                        op;
    logic [mkse_pkg::PORT_W-1:0] port_sample;

    modport source (output valid, output op, output port_sample, input ready);
    modport sink   (input valid, input op, input port_sample, output ready);
endinterface

interface mkse_out_if;
    logic                        valid;
    logic                        ready;
    logic [mkse_pkg::PORT_W-1:0] port_drive;
    logic                        has_event;
    logic [mkse_pkg::KEY_W-1:0]  key_index;
    logic                        pressed;
    logic                        last;

    modport source (output valid, output port_drive, output has_event, output key_index,
                    output pressed, output last, input ready);
    modport sink   (input valid, input port_drive, input has_event, input key_index,
                    input pressed, input last, output ready);
endinterface

// ===== sv/mkse_datapath.sv =====
// scan state, key set, change walk and output register
// depends on mkse_pkg
module mkse_datapath #(
    parameter int NUM_COLUMNS = mkse_pkg::NUM_COLUMNS_DEF,
    parameter int NUM_ROWS    = mkse_pkg::NUM_ROWS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mkse_pkg::t_cmd              i_cmd,
    output mkse_pkg::t_stat             o_stat,
    input  logic                        i_op,
    input  logic [mkse_pkg::PORT_W-1:0] i_port_sample,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [mkse_pkg::PORT_W-1:0] o_port_drive,
    output logic                        o_has_event,
    output logic [mkse_pkg::KEY_W-1:0]  o_key_index,
    output logic                        o_pressed,
    output logic                        o_last
);

    logic                        r_scanning;
    logic [mkse_pkg::COL_W-1:0]  r_col;
    logic [mkse_pkg::KEYS-1:0]   r_mask;
    logic [mkse_pkg::KEYS-1:0]   r_keys;
    logic [mkse_pkg::KEYS-1:0]   r_changed;
    logic [mkse_pkg::KEY_W-1:0]  r_bit;
    logic [mkse_pkg::PORT_W-1:0] r_drive;
    logic                        r_out_valid;
    logic [mkse_pkg::PORT_W-1:0] r_out_drive;
    logic                        r_out_event;
    logic [mkse_pkg::KEY_W-1:0]  r_out_key;
    logic                        r_out_pressed;
    logic                        r_out_last;

    logic [mkse_pkg::KEYS-1:0]   n_mask;
    logic                        w_col_last;
    logic [mkse_pkg::COL_W-1:0]  w_col_next;

    // merge the pressed rows of the current column into the mask
    always_comb begin
        n_mask = r_mask;
        for (int r = 0; r < NUM_ROWS; r++) begin
            if (i_port_sample[4 + r]) begin
                n_mask[{mkse_pkg::COL_W'(r), r_col}] = 1'b1;
            end
        end
    end

    assign w_col_last = (r_col == mkse_pkg::COL_W'(NUM_COLUMNS - 1));
    assign w_col_next = r_col + mkse_pkg::COL_W'(1);

    // status toward the controller
    assign o_stat.go_walk     = (i_op == mkse_pkg::OP_SAMPLE) && r_scanning && w_col_last;
    assign o_stat.bit_changed = r_changed[r_bit];
    assign o_stat.bit_end     = (r_bit == mkse_pkg::KEY_W'(mkse_pkg::KEYS - 1));
    assign o_stat.out_free    = !r_out_valid || i_out_ready;

    // scan state and key set
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scanning <= 1'b0;
            r_col      <= '0;
            r_mask     <= '0;
            r_keys     <= '0;
        end else if (i_cmd.accept) begin
            if (i_op == mkse_pkg::OP_START) begin
                r_scanning <= 1'b1;
                r_col      <= '0;
                r_mask     <= '0;
            end else if (r_scanning && !w_col_last) begin
                r_mask <= n_mask;
                r_col  <= w_col_next;
            end else if (r_scanning) begin
                r_keys     <= n_mask;
                r_mask     <= '0;
                r_scanning <= 1'b0;
                r_col      <= '0;
            end
        end
    end

    // pending drive, change vector and walk index
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_bit <= '0;
            if (i_op == mkse_pkg::OP_START) begin
                r_drive <= mkse_pkg::col_drive('0);
            end else if (r_scanning && !w_col_last) begin
                r_drive <= mkse_pkg::col_drive(w_col_next);
            end else begin
                r_drive <= mkse_pkg::IDLE_DRIVE;
            end
            if (r_scanning && w_col_last) begin
                r_changed <= r_keys ^ n_mask;
            end
        end else if (i_cmd.step) begin
            r_bit <= r_bit + mkse_pkg::KEY_W'(1);
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_event || i_cmd.load_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_event) begin
            r_out_drive   <= mkse_pkg::IDLE_DRIVE;
            r_out_event   <= 1'b1;
            r_out_key     <= r_bit;
            r_out_pressed <= r_keys[r_bit];
            r_out_last    <= 1'b0;
        end else if (i_cmd.load_last) begin
            r_out_drive   <= r_drive;
            r_out_event   <= 1'b0;
            r_out_key     <= '0;
            r_out_pressed <= 1'b0;
            r_out_last    <= 1'b1;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_port_drive = r_out_drive;
    assign o_has_event  = r_out_event;
    assign o_key_index  = r_out_key;
    assign o_pressed    = r_out_pressed;
    assign o_last       = r_out_last;

endmodule

// ===== sv/mkse_ctrl.sv =====
// sequencer: accept, walk the changed keys, emit the closing result
// depends on mkse_pkg
module mkse_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  mkse_pkg::t_stat i_stat,
    output mkse_pkg::t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_LAST
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = i_stat.go_walk ? S_WALK : S_LAST;
                end
            end
            S_WALK: begin
                // unchanged keys pass without waiting for the output slot
                o_cmd.step       = !i_stat.bit_changed || i_stat.out_free;
                o_cmd.load_event = i_stat.bit_changed && i_stat.out_free;
                if (o_cmd.step && i_stat.bit_end) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                o_cmd.load_last = i_stat.out_free;
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// ===== sv/matrix_keypad_scan_events.sv =====
// results pass the controller state register, then the output register
// a new sample is taken only after the previous one's results are loaded;
// after a last-column sample the change walk visits one key index per cycle,
// but an event waits in the walk while the output register is held
// reset: synchronous active low; idle, no keys held, output empty
`include "assert_macros.svh"

module matrix_keypad_scan_events #(
    parameter int NUM_COLUMNS = mkse_pkg::NUM_COLUMNS_DEF,
    parameter int NUM_ROWS    = mkse_pkg::NUM_ROWS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mkse_in_if.sink     i_in,
    mkse_out_if.source  o_out
);

    mkse_pkg::t_cmd  w_cmd;
    mkse_pkg::t_stat w_stat;

    // controller
    mkse_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // datapath
    mkse_datapath #(
        .NUM_COLUMNS (NUM_COLUMNS),
        .NUM_ROWS    (NUM_ROWS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_op          (i_in.op),
        .i_port_sample (i_in.port_sample),
        .o_out_valid   (o_out.valid),
        .i_out_ready   (o_out.ready),
        .o_port_drive  (o_out.port_drive),
        .o_has_event   (o_out.has_event),
        .o_key_index   (o_out.key_index),
        .o_pressed     (o_out.pressed),
        .o_last        (o_out.last)
    );

    // checks on the sequencing
    `ASSERT_IMPL(a_event_not_last, i_clk, i_rst_n, o_out.valid && o_out.has_event, !o_out.last)
    `ASSERT_IMPL(a_plain_zero, i_clk, i_rst_n, o_out.valid && !o_out.has_event, o_out.key_index == '0 && !o_out.pressed)
    `ASSERT_IMPL(a_no_take_in_walk, i_clk, i_rst_n, w_cmd.load_event, !i_in.ready)
    `ASSERT_IMPL(a_load_needs_slot, i_clk, i_rst_n, w_cmd.load_event || w_cmd.load_last, w_stat.out_free)
    `ASSERT_NEXT(a_load_sets_valid, i_clk, i_rst_n, w_cmd.load_event || w_cmd.load_last, o_out.valid)

endmodule
